// ===== hdl/hdlc_bsf_pkg.sv =====
// Shared constants, types and helpers for the HDLC byte-stuffing framer.
// No dependencies; used by the framer top level and its port checker.
package hdlc_bsf_pkg;

    localparam logic [7:0] FRAME_FLAG  = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0] ESC_FOR_7E  = 8'h5E;
    localparam logic [7:0] ESC_FOR_7D  = 8'h5D;

    localparam logic [7:0] ADDRESS_RESET = 8'h03;
    localparam logic [7:0] CONTROL_RESET = 8'h00;

    // Configuration register indexes.
    localparam logic CFG_ADDRESS = 1'b0;
    localparam logic CFG_CONTROL = 1'b1;

    // Output slots of one transaction, in line order.
    localparam int NUM_SLOTS = 9;

    typedef logic [3:0]           slot_idx_t;
    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    localparam slot_idx_t SLOT_OPEN  = 4'd0;
    localparam slot_idx_t SLOT_ADDR  = 4'd1;
    localparam slot_idx_t SLOT_CTRL  = 4'd2;
    localparam slot_idx_t SLOT_HCS   = 4'd3;
    localparam slot_idx_t SLOT_DATA0 = 4'd4;
    localparam slot_idx_t SLOT_DATA1 = 4'd5;
    localparam slot_idx_t SLOT_CHK0  = 4'd6;
    localparam slot_idx_t SLOT_CHK1  = 4'd7;
    localparam slot_idx_t SLOT_CLOSE = 4'd8;

    // True when a byte must be sent as an escape pair.
    function automatic logic needs_escape(input logic [7:0] value);
        return (value == FRAME_FLAG) || (value == ESCAPE_BYTE);
    endfunction

    // First byte of the stuffed form of a value.
    function automatic logic [7:0] stuff_head(input logic [7:0] value);
        return needs_escape(value) ? ESCAPE_BYTE : value;
    endfunction

    // Second byte of an escape pair.
    function automatic logic [7:0] stuff_tail(input logic [7:0] value);
        return (value == FRAME_FLAG) ? ESC_FOR_7E : ESC_FOR_7D;
    endfunction

endpackage

// ===== hdl/hdlc_byte_stuffing_framer_top.sv =====
// Top level of the HDLC byte-stuffing framer with XOR block check.
// Depends on hdlc_bsf_pkg for constants, slot codes and stuffing helpers.
//
//  Channel  | Ports                                  | Direction | Carries
//  ---------+----------------------------------------+-----------+--------------------------
//  s_       | s_valid/s_ready, s_data_byte, s_frame_* | in        | one payload byte + marks
//  m_       | m_valid/m_ready, m_out_byte, m_out_last | out       | one line byte per beat
//  cfg_     | cfg_wr_en, cfg_index, cfg_wr_data       | in        | address / control write
//
// Each input transaction produces between one and nine line bytes, and the output
// register issues exactly one byte per cycle unless a stall on m_ready holds it.
// The next transaction is taken in the same cycle its predecessor's final byte moves
// into the output register, so the line side never idles while input is waiting.
// Reset (aresetn low at a clock edge) empties the item and output registers, clears the
// running check and restores address 0x03 and control 0x00.
// A stall on m_ready holds the output register and, once the item register is waiting
// on it, drops s_ready; nothing is lost or repeated.
module hdlc_byte_stuffing_framer_top (
    input  logic       aclk,
    input  logic       aresetn,
    // Input transaction channel.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_frame_first,
    input  logic       s_frame_last,
    // Result transaction channel.
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last,
    // Configuration write port.
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wr_data
);

    // Configuration registers.
    logic [7:0] address_reg;
    logic [7:0] control_reg;

    // Running XOR of the payload of the open frame.
    logic [7:0] running_check_reg;
    logic [7:0] running_check_next;

    // Item register: the accepted transaction and the slots it still has to send.
    // A nonzero slot mask means the item register holds work.
    hdlc_bsf_pkg::slot_mask_t mask_reg;
    hdlc_bsf_pkg::slot_mask_t mask_next;
    logic [7:0]               data_reg;
    logic [7:0]               chk_reg;

    // Output register.
    logic       m_valid_reg;
    logic [7:0] m_out_byte_reg;
    logic       m_out_last_reg;

    // Datapath signals.
    logic                      item_valid;
    logic                      move;
    logic                      accept;
    logic [7:0]                acc_chk;
    hdlc_bsf_pkg::slot_mask_t  acc_mask;
    hdlc_bsf_pkg::slot_idx_t   cur_slot;
    hdlc_bsf_pkg::slot_mask_t  cur_onehot;
    hdlc_bsf_pkg::slot_mask_t  remain_mask;
    logic                      remain_empty;
    logic [7:0]                slot_byte;

    assign item_valid   = |mask_reg;
    assign move         = item_valid && (!m_valid_reg || m_ready);
    assign remain_empty = (remain_mask == '0);
    // A new transaction enters when the item register is empty or hands off its final byte.
    assign s_ready      = !item_valid || (move && remain_empty);
    assign accept       = s_valid && s_ready;

    // Check value as it stands after this byte; a first mark restarts the frame.
    assign acc_chk = (s_frame_first ? 8'h00 : running_check_reg) ^ s_data_byte;

    // Build the list of line bytes this transaction will produce.
    always_comb begin
        acc_mask = '0;
        acc_mask[hdlc_bsf_pkg::SLOT_OPEN]  = s_frame_first;
        acc_mask[hdlc_bsf_pkg::SLOT_ADDR]  = s_frame_first;
        acc_mask[hdlc_bsf_pkg::SLOT_CTRL]  = s_frame_first;
        acc_mask[hdlc_bsf_pkg::SLOT_HCS]   = s_frame_first;
        acc_mask[hdlc_bsf_pkg::SLOT_DATA0] = 1'b1;
        acc_mask[hdlc_bsf_pkg::SLOT_DATA1] = hdlc_bsf_pkg::needs_escape(s_data_byte);
        acc_mask[hdlc_bsf_pkg::SLOT_CHK0]  = s_frame_last;
        acc_mask[hdlc_bsf_pkg::SLOT_CHK1]  = s_frame_last && hdlc_bsf_pkg::needs_escape(acc_chk);
        acc_mask[hdlc_bsf_pkg::SLOT_CLOSE] = s_frame_last;
    end

    // The lowest pending slot goes out next.
    always_comb begin
        cur_slot = hdlc_bsf_pkg::SLOT_OPEN;
        for (int i = hdlc_bsf_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                cur_slot = hdlc_bsf_pkg::slot_idx_t'(i);
            end
        end
    end

    assign cur_onehot  = hdlc_bsf_pkg::slot_mask_t'(1) << cur_slot;
    assign remain_mask = mask_reg & ~cur_onehot;

    // Byte for the current slot. Header fields go out unstuffed.
    always_comb begin
        unique case (cur_slot)
            hdlc_bsf_pkg::SLOT_OPEN:  slot_byte = hdlc_bsf_pkg::FRAME_FLAG;
            hdlc_bsf_pkg::SLOT_ADDR:  slot_byte = address_reg;
            hdlc_bsf_pkg::SLOT_CTRL:  slot_byte = control_reg;
            hdlc_bsf_pkg::SLOT_HCS:   slot_byte = address_reg ^ control_reg;
            hdlc_bsf_pkg::SLOT_DATA0: slot_byte = hdlc_bsf_pkg::stuff_head(data_reg);
            hdlc_bsf_pkg::SLOT_DATA1: slot_byte = hdlc_bsf_pkg::stuff_tail(data_reg);
            hdlc_bsf_pkg::SLOT_CHK0:  slot_byte = hdlc_bsf_pkg::stuff_head(chk_reg);
            hdlc_bsf_pkg::SLOT_CHK1:  slot_byte = hdlc_bsf_pkg::stuff_tail(chk_reg);
            hdlc_bsf_pkg::SLOT_CLOSE: slot_byte = hdlc_bsf_pkg::FRAME_FLAG;
            default:                  slot_byte = hdlc_bsf_pkg::FRAME_FLAG;
        endcase
    end

    always_comb begin
        mask_next = mask_reg;
        if (accept) begin
            mask_next = acc_mask;
        end else if (move) begin
            mask_next = remain_mask;
        end
    end

    // The check closes with the frame, so the next frame starts from zero.
    always_comb begin
        running_check_next = running_check_reg;
        if (accept) begin
            running_check_next = s_frame_last ? 8'h00 : acc_chk;
        end
    end

    // Control state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg          <= '0;
            running_check_reg <= 8'h00;
            m_valid_reg       <= 1'b0;
            address_reg       <= hdlc_bsf_pkg::ADDRESS_RESET;
            control_reg       <= hdlc_bsf_pkg::CONTROL_RESET;
        end else begin
            mask_reg          <= mask_next;
            running_check_reg <= running_check_next;
            if (move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    hdlc_bsf_pkg::CFG_ADDRESS: address_reg <= cfg_wr_data;
                    hdlc_bsf_pkg::CFG_CONTROL: control_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= s_data_byte;
            chk_reg  <= acc_chk;
        end
        if (move) begin
            m_out_byte_reg <= slot_byte;
            m_out_last_reg <= remain_empty;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_out_last = m_out_last_reg;

endmodule

// ===== hdl/hdlc_bsf_checker.sv =====
// Port-level checker for the HDLC byte-stuffing framer, bound to its top level.
// Depends on hdlc_bsf_pkg for the line byte constants.
module hdlc_bsf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_data_byte,
    input logic       s_frame_first,
    input logic       s_frame_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_out_last,
    input logic       cfg_wr_en,
    input logic       cfg_index,
    input logic [7:0] cfg_wr_data
);

    // A stalled result holds its byte and marker.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_last))
        else $error("result changed while stalled");

    // Reset leaves the output side empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A transaction never ends on an escape byte: its pair partner always follows.
    a_no_dangling_escape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_last |-> m_out_byte != hdlc_bsf_pkg::ESCAPE_BYTE)
        else $error("transaction ended on an escape byte");

    // A final byte taken by the receiver is never an escape byte when another result follows it.
    a_escape_not_last_stuffed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_out_last |=> !(m_valid && $past(m_out_byte) ==
            hdlc_bsf_pkg::ESCAPE_BYTE))
        else $error("escape byte closed a transaction");

endmodule

bind hdlc_byte_stuffing_framer_top hdlc_bsf_checker u_hdlc_bsf_checker (.*);
